// ===== rtl/page_table_map_unmap_assert.svh =====
// Assertion macros for the page table mapper.
`ifndef PAGE_TABLE_MAP_UNMAP_ASSERT_SVH
`define PAGE_TABLE_MAP_UNMAP_ASSERT_SVH
`ifndef SYNTHESIS
`define PTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page table mapper assertion failed");
`define PTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page table mapper assertion failed");
`else
`define PTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ptm_pkg.sv =====
// Shared types and codes of the page table mapper.
package ptm_pkg;

  localparam int ENTRY_W = 44;
  localparam int IDX_W   = 9;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NONCANON   = 2'd1;
  localparam logic [1:0] ST_NO_PRESENT = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd3;

  localparam logic REQ_MAP   = 1'b0;
  localparam logic REQ_UNMAP = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] address;
    logic [7:0]  flags;
  } ptm_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        invalidate;
    logic [35:0] page_number;
  } ptm_res_t;

endpackage

// ===== rtl/page_table_map_unmap.sv =====
// Top level of the four-level page table mapper.
// Requests enter on in_valid/in_ready: in_req_type (0 map, 1 unmap),
// in_address (48-bit canonical byte address) and in_flags (bit 0 Present).
// Each request gives one result on out_valid/out_ready: out_status,
// out_invalidate and out_page_number (address bits 47..12 when invalidate).
// The tables live in one memory of POOL_PAGES*512 entries, with one read
// and one write port; each table access reads an entry, then may update it.
// A map first walks the tables to count the table pages it needs, then
// walks them again, allocating a pool page for each missing table; an unmap
// walks the tables, clears the leaf entry and checks table pages bottom up
// for emptiness (one to three; a check stops at the first present entry).
// One request is in work at a time; in_ready is high only while idle.
// After reset a clearing pass writes every table entry and the pool map,
// with in_ready low.
// A finished result sits in an output register; a stalled receiver holds it,
// and the block can take one further request meanwhile, its own result
// waiting until the register frees.
`include "page_table_map_unmap_assert.svh"
module page_table_map_unmap import ptm_pkg::*; #(
  parameter int POOL_PAGES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [63:0] in_address,
  input  logic [7:0]  in_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_invalidate,
  output logic [35:0] out_page_number
);

  ptm_req_t req;
  ptm_res_t res, res_r;
  logic     idle, res_valid, res_ready;
  logic     out_valid_r;

  assign req.req_type = in_req_type;
  assign req.address  = in_address;
  assign req.flags    = in_flags;

  assign in_ready  = idle;
  assign res_ready = !out_valid_r || out_ready;

  ptm_walk #(.POOL_PAGES(POOL_PAGES)) u_walk (
    .clk(clk), .rst_n(rst_n), .start(in_valid && idle), .req(req), .idle(idle),
    .res_ready(res_ready), .res_valid(res_valid), .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_invalidate  = res_r.invalidate;
  assign out_page_number = res_r.page_number;

  // checks
  `PTM_ASSERT_IMP(a_err_no_inv, clk, rst_n, out_valid && out_status != ST_OK, !out_invalidate)
  `PTM_ASSERT_IMP(a_vpn_zero, clk, rst_n, out_valid && !out_invalidate, out_page_number == 36'd0)
  `PTM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

// ===== rtl/ptm_ram.sv =====
// Single write port, single registered read port memory.
module ptm_ram #(
  parameter int W  = 44,
  parameter int D  = 32768,
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [W-1:0]  wd,
  input  logic [AW-1:0] ra,
  output logic [W-1:0]  rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

// ===== rtl/ptm_walk.sv =====
// Table walk sequencer: clear pass, map, unmap and page free scans.
module ptm_walk import ptm_pkg::*; #(
  parameter int POOL_PAGES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  ptm_req_t req,
  output logic     idle,
  input  logic     res_ready,
  output logic     res_valid,
  output ptm_res_t res
);

  localparam int PW    = $clog2(POOL_PAGES);
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = POOL_PAGES * 512;

  typedef enum logic [14:0] {
    S_CLR    = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_CNT_RD = 15'b000000000000100,
    S_CNT_EV = 15'b000000000001000,
    S_CHECK  = 15'b000000000010000,
    S_MAP_RD = 15'b000000000100000,
    S_MAP_EV = 15'b000000001000000,
    S_AL_RD  = 15'b000000010000000,
    S_AL_EV  = 15'b000000100000000,
    S_UN_RD  = 15'b000001000000000,
    S_UN_EV  = 15'b000010000000000,
    S_FREE   = 15'b000100000000000,
    S_SC_RD  = 15'b001000000000000,
    S_SC_EV  = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t          state_r, state_nxt;
  ptm_req_t        req_r, req_nxt;
  logic [1:0]      lvl_r, lvl_nxt;
  logic [PW-1:0]   page_r, page_nxt;
  logic [PW-1:0]   pg_r [4];
  logic [PW-1:0]   pg_nxt [4];
  logic [1:0]      need_r, need_nxt;
  logic [PW-1:0]   scan_r, scan_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [PW-1:0]   free_r, free_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            inv_r, inv_nxt;

  // memory ports
  logic               t_we, u_we, u_wd;
  logic [AW-1:0]      t_wa, t_ra;
  logic [ENTRY_W-1:0] t_wd, t_rd;
  logic [PW-1:0]      u_wa, u_ra;
  logic               u_rd;

  logic [IDX_W-1:0] idx_cur, idx_par;
  logic [1:0]       lvl_m1;
  logic [PW-1:0]    frame_e;
  logic             present;
  logic [7:0]       fl;
  logic [35:0]      vpn;

  function automatic logic [IDX_W-1:0] lvl_idx(logic [63:0] a, logic [1:0] l);
    logic [IDX_W-1:0] r;
    case (l)
      2'd0:    r = a[47:39];
      2'd1:    r = a[38:30];
      2'd2:    r = a[29:21];
      default: r = a[20:12];
    endcase
    return r;
  endfunction

  assign lvl_m1  = lvl_r - 2'd1;
  assign idx_cur = lvl_idx(req_r.address, lvl_r);
  assign idx_par = lvl_idx(req_r.address, lvl_m1);
  assign frame_e = t_rd[8 +: PW];
  assign present = t_rd[0];
  assign fl      = req_r.flags;
  assign vpn     = req_r.address[47:12];

  ptm_ram #(.W(ENTRY_W), .D(DEPTH), .AW(AW)) u_table (
    .clk(clk), .we(t_we), .wa(t_wa), .wd(t_wd), .ra(t_ra), .rd(t_rd)
  );

  ptm_ram #(.W(1), .D(POOL_PAGES), .AW(PW)) u_inuse (
    .clk(clk), .we(u_we), .wa(u_wa), .wd(u_wd), .ra(u_ra), .rd(u_rd)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    lvl_nxt    = lvl_r;
    page_nxt   = page_r;
    pg_nxt     = pg_r;
    need_nxt   = need_r;
    scan_nxt   = scan_r;
    cnt_nxt    = cnt_r;
    clr_nxt    = clr_r;
    free_nxt   = free_r;
    status_nxt = status_r;
    inv_nxt    = inv_r;
    t_we = 1'b0;
    t_wa = {page_r, idx_cur};
    t_wd = '0;
    t_ra = {page_r, idx_cur};
    u_we = 1'b0;
    u_wa = scan_r;
    u_wd = 1'b0;
    u_ra = scan_r;
    case (state_r)
      S_CLR: begin
        t_we = 1'b1;
        t_wa = clr_r;
        if (clr_r < AW'(POOL_PAGES)) begin
          u_we = 1'b1;
          u_wa = clr_r[PW-1:0];
          u_wd = (clr_r == '0);
        end
        if (clr_r == AW'(DEPTH - 1)) begin
          free_nxt  = PW'(POOL_PAGES - 1);
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt    = req;
          lvl_nxt    = 2'd0;
          page_nxt   = '0;
          pg_nxt[0]  = '0;
          inv_nxt    = 1'b0;
          status_nxt = ST_OK;
          if (req.address[63:48] != 16'd0) begin
            status_nxt = ST_NONCANON;
            state_nxt  = S_DONE;
          end else if (req.req_type == REQ_UNMAP) begin
            state_nxt = S_UN_RD;
          end else if (!req.flags[0]) begin
            status_nxt = ST_NO_PRESENT;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_CNT_RD;
          end
        end
      end
      // count the table pages a map needs
      S_CNT_RD: state_nxt = S_CNT_EV;
      S_CNT_EV: begin
        if (!present) begin
          need_nxt  = 2'd3 - lvl_r;
          state_nxt = S_CHECK;
        end else if (lvl_r == 2'd2) begin
          need_nxt  = 2'd0;
          state_nxt = S_CHECK;
        end else begin
          page_nxt  = frame_e;
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = S_CNT_RD;
        end
      end
      S_CHECK: begin
        if (PW'(need_r) > free_r) begin
          status_nxt = ST_EXHAUSTED;
          state_nxt  = S_DONE;
        end else begin
          lvl_nxt   = 2'd0;
          page_nxt  = '0;
          state_nxt = S_MAP_RD;
        end
      end
      // map walk with read-modify-write
      S_MAP_RD: state_nxt = S_MAP_EV;
      S_MAP_EV: begin
        if (lvl_r == 2'd3) begin
          if ((t_rd[7:0] & fl) != fl) begin
            t_we    = 1'b1;
            t_wd    = {vpn, fl};
            inv_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else if ((t_rd[7:0] & fl) == fl) begin
          page_nxt  = frame_e;
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = S_MAP_RD;
        end else if (present) begin
          t_we      = 1'b1;
          t_wd      = {t_rd[ENTRY_W-1:8], fl};
          inv_nxt   = 1'b1;
          page_nxt  = frame_e;
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = S_MAP_RD;
        end else begin
          scan_nxt  = PW'(1);
          state_nxt = S_AL_RD;
        end
      end
      // lowest free pool page; freed pages are already all zero
      S_AL_RD: state_nxt = S_AL_EV;
      S_AL_EV: begin
        if (!u_rd) begin
          u_we      = 1'b1;
          u_wd      = 1'b1;
          free_nxt  = free_r - 1'b1;
          t_we      = 1'b1;
          t_wd      = {{(36 - PW){1'b0}}, scan_r, fl};
          inv_nxt   = 1'b1;
          page_nxt  = scan_r;
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = S_MAP_RD;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_AL_RD;
        end
      end
      // unmap walk
      S_UN_RD: state_nxt = S_UN_EV;
      S_UN_EV: begin
        if (!present) begin
          state_nxt = S_DONE;
        end else if (lvl_r == 2'd3) begin
          t_we      = 1'b1;
          inv_nxt   = 1'b1;
          state_nxt = S_FREE;
        end else begin
          pg_nxt[lvl_r + 2'd1] = frame_e;
          page_nxt  = frame_e;
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = S_UN_RD;
        end
      end
      // free empty table pages bottom up, never the root
      S_FREE: begin
        if (pg_r[lvl_r] == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        t_ra      = {pg_r[lvl_r], cnt_r};
        state_nxt = S_SC_EV;
      end
      S_SC_EV: begin
        if (present) begin
          state_nxt = S_DONE;
        end else if (cnt_r == '1) begin
          u_we     = 1'b1;
          u_wa     = pg_r[lvl_r];
          free_nxt = free_r + 1'b1;
          t_we     = 1'b1;
          t_wa     = {pg_r[lvl_m1], idx_par};
          lvl_nxt  = lvl_m1;
          state_nxt = (lvl_r == 2'd1) ? S_DONE : S_FREE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_SC_RD;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      free_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    lvl_r    <= lvl_nxt;
    page_r   <= page_nxt;
    pg_r     <= pg_nxt;
    need_r   <= need_nxt;
    scan_r   <= scan_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    inv_r    <= inv_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.status      = status_r;
  assign res.invalidate  = inv_r;
  assign res.page_number = inv_r ? vpn : 36'd0;

endmodule

// ===== dv/page_table_map_unmap_tb.sv =====
// Testbench for the four-level page table mapper, with its own table predictor.
module page_table_map_unmap_tb;
  import ptm_pkg::*;

  localparam int POOL = 64;
  localparam int LEVEL_SLOTS = 512;
  localparam int LIMIT = 20000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = REQ_MAP;
  logic [63:0] in_address = '0;
  logic [7:0]  in_flags = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_invalidate;
  logic [35:0] out_page_number;

  page_table_map_unmap #(.POOL_PAGES(POOL)) DUT (.*);

  always #5 clk = ~clk;

  // predictor state: table entries by slot (absent key reads as zero) and pool map
  logic [43:0] table_entry [int unsigned];
  bit          page_used [POOL];
  ptm_res_t    expected_results [$];
  bit          no_idle = 1'b0;
  int          errors = 0;
  int          cycles = 0;
  int          status_count [4] = '{0, 0, 0, 0};
  int          unmap_count = 0;

  function automatic logic [43:0] read_entry(int unsigned slot);
    return table_entry.exists(slot) ? table_entry[slot] : 44'd0;
  endfunction

  function automatic int unsigned slot_at(int unsigned pg, logic [8:0] idx);
    return pg * LEVEL_SLOTS + idx;
  endfunction

  function automatic int unsigned frame_page(logic [43:0] e);
    return e[43:8] % POOL;
  endfunction

  function automatic int unsigned alloc_page();
    for (int i = 1; i < POOL; i++) begin
      if (!page_used[i]) begin
        page_used[i] = 1'b1;
        for (int k = 0; k < LEVEL_SLOTS; k++) table_entry.delete(i * LEVEL_SLOTS + k);
        return i;
      end
    end
    return 0;
  endfunction

  function automatic bit page_has_none(int unsigned pg);
    for (int k = 0; k < LEVEL_SLOTS; k++)
      if (read_entry(pg * LEVEL_SLOTS + k) & 44'd1) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one request to the predicted tables and return its result.
  function automatic ptm_res_t predict_mapping(logic rt, logic [63:0] addr, logic [7:0] fl);
    ptm_res_t r;
    logic [8:0] idx [4];
    logic [35:0] vpn;
    logic [43:0] e;
    int unsigned pg [4];
    int unsigned need, free_cnt, s;
    bit ok;
    r = '0;
    vpn = addr[47:12];
    idx[0] = addr[47:39];
    idx[1] = addr[38:30];
    idx[2] = addr[29:21];
    idx[3] = addr[20:12];
    if (addr[63:48] != 0) begin
      r.status = ST_NONCANON;
    end else if (rt == REQ_MAP) begin
      if (!fl[0]) begin
        r.status = ST_NO_PRESENT;
      end else begin
        need = 0;
        pg[0] = 0;
        for (int l = 0; l < 3; l++) begin
          e = read_entry(slot_at(pg[0], idx[l]));
          if (!e[0]) begin
            need = 3 - l;
            break;
          end
          pg[0] = frame_page(e);
        end
        free_cnt = 0;
        foreach (page_used[i]) if (!page_used[i]) free_cnt++;
        if (need > free_cnt) begin
          r.status = ST_EXHAUSTED;
        end else begin
          pg[0] = 0;
          for (int l = 0; l < 3; l++) begin
            s = slot_at(pg[0], idx[l]);
            e = read_entry(s);
            if ((e[7:0] & fl) != fl) begin
              if (!e[0]) e = {36'(alloc_page()), 8'd0};
              e[7:0] = fl;
              table_entry[s] = e;
              r.invalidate = 1'b1;
            end
            pg[0] = frame_page(e);
          end
          s = slot_at(pg[0], idx[3]);
          if ((read_entry(s) & {36'd0, fl}) != {36'd0, fl}) begin
            table_entry[s] = {vpn, fl};
            r.invalidate = 1'b1;
          end
        end
      end
    end else begin
      ok = 1'b1;
      pg[0] = 0;
      for (int l = 0; l < 3 && ok; l++) begin
        e = read_entry(slot_at(pg[l], idx[l]));
        if (!e[0]) ok = 1'b0;
        else pg[l + 1] = frame_page(e);
      end
      if (ok && read_entry(slot_at(pg[3], idx[3])) & 44'd1) begin
        table_entry.delete(slot_at(pg[3], idx[3]));
        r.invalidate = 1'b1;
        // release emptied table pages bottom up, root stays
        for (int l = 3; l >= 1; l--) begin
          if (pg[l] == 0 || !page_has_none(pg[l])) break;
          page_used[pg[l]] = 1'b0;
          table_entry.delete(slot_at(pg[l - 1], idx[l - 1]));
        end
      end
    end
    if (r.invalidate) r.page_number = vpn;
    return r;
  endfunction

  // Send one request; called at a rising edge, returns at its acceptance edge.
  task automatic send_request(logic rt, logic [63:0] addr, logic [7:0] fl);
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_address  <= addr;
    in_flags    <= fl;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_mapping(rt, addr, fl));
    status_count[expected_results[$].status]++;
    if (rt == REQ_UNMAP) unmap_count++;
  endtask

  function automatic logic [8:0] pick_index();
    logic [8:0] common [4] = '{9'd0, 9'd1, 9'd2, 9'd511};
    return ($urandom_range(0, 9) < 7) ? common[$urandom_range(0, 3)] : 9'($urandom_range(0, 511));
  endfunction

  function automatic logic [63:0] make_address(logic [8:0] i0, logic [8:0] i1,
                                               logic [8:0] i2, logic [8:0] i3);
    return {16'd0, i0, i1, i2, i3, 12'($urandom_range(0, 4095))};
  endfunction

  task automatic test_errors();
    send_request(REQ_MAP, {16'hFFFF, 48'h0000_1234_5000}, 8'h03);
    send_request(REQ_UNMAP, {16'h0001, 48'd0}, 8'h00);
    send_request(REQ_MAP, {16'h8000, 48'hFFFF_FFFF_FFFF}, 8'hFE);
    send_request(REQ_MAP, 64'h0000_7FFF_FFFF_F000, 8'h00);
    send_request(REQ_MAP, 64'h0000_0000_0040_0000, 8'hFE);
  endtask

  task automatic test_map_unmap();
    send_request(REQ_UNMAP, 64'h0000_0000_0000_1000, 8'hFF);
    send_request(REQ_MAP, 64'h0000_FFFF_FFFF_FFFF, 8'hFF);
    send_request(REQ_MAP, 64'h0000_FFFF_FFFF_F000, 8'h01);
    send_request(REQ_MAP, 64'h0000_0000_0000_0000, 8'h01);
    send_request(REQ_MAP, 64'h0000_0000_0000_0ABC, 8'h03);
    send_request(REQ_MAP, 64'h0000_0000_0000_1000, 8'h01);
    send_request(REQ_UNMAP, 64'h0000_0000_0000_0000, 8'h00);
    send_request(REQ_UNMAP, 64'h0000_0000_0000_1000, 8'h5A);
    send_request(REQ_UNMAP, 64'h0000_FFFF_FFFF_FFFF, 8'h00);
    send_request(REQ_UNMAP, 64'h0000_FFFF_FFFF_FFFF, 8'h00);
  endtask

  // each new top-level index costs three pages, so the pool runs dry
  task automatic test_pool_exhaustion();
    for (int i = 1; i <= 23; i++) send_request(REQ_MAP, 64'(i) << 39, 8'h07);
    for (int i = 23; i >= 1; i--) send_request(REQ_UNMAP, 64'(i) << 39, 8'h00);
  endtask

  task automatic test_random(int n);
    logic [63:0] addr;
    logic rt;
    for (int k = 0; k < n; k++) begin
      no_idle = (k >= 200 && k < 320);
      addr = make_address(pick_index(), pick_index(), pick_index(), pick_index());
      if ($urandom_range(0, 99) < 5) addr[63:48] = 16'($urandom_range(1, 65535));
      rt = ($urandom_range(0, 99) < 40) ? REQ_UNMAP : REQ_MAP;
      send_request(rt, addr,
                   ($urandom_range(0, 99) < 8) ? 8'($urandom) & 8'hFE : 8'($urandom) | 8'h01);
    end
    no_idle = 1'b0;
  endtask

  // result receiver stalls at random
  always @(posedge clk) begin
    out_ready <= (no_idle || $urandom_range(0, 99) >= 15);
  end

  // compare each delivered result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: status %0d", out_status);
        errors++;
      end else begin
        ptm_res_t x;
        x = expected_results.pop_front();
        if (out_status !== x.status) begin
          $error("status: expected %0d, got %0d", x.status, out_status);
          errors++;
        end
        if (out_invalidate !== x.invalidate) begin
          $error("invalidate: expected %0d, got %0d", x.invalidate, out_invalidate);
          errors++;
        end
        if (out_page_number !== x.page_number) begin
          $error("page_number: expected %h, got %h", x.page_number, out_page_number);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("page_table_map_unmap: mismatch");
      $finish;
    end
  end

  initial begin
    page_used[0] = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_errors();
    test_map_unmap();
    test_pool_exhaustion();
    test_random(650);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d requests (%0d unmaps): %0d ok, %0d noncanonical,",
             status_count[0] + status_count[1] + status_count[2] + status_count[3],
             unmap_count, status_count[0], status_count[1]);
    $display("  %0d without Present, %0d with the table pool exhausted.",
             status_count[2], status_count[3]);
    if (errors == 0) begin
      $display("page_table_map_unmap: match");
    end else begin
      $display("page_table_map_unmap: mismatch");
    end
    $finish;
  end

endmodule
